// ===== rtl/accel_collision_detector_macros.svh =====
// ----------------------------------------------------------------------------
// accel_collision_detector_macros.svh
// Assertion macros shared by the collision detector RTL.
// ----------------------------------------------------------------------------
`ifndef ACCEL_COLLISION_DETECTOR_MACROS_SVH
`define ACCEL_COLLISION_DETECTOR_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check, disabled while reset is high.
`define ACD_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("acd assertion failed");
// Clocked check that also holds through reset.
`define ACD_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("acd assertion failed");
`else
`define ACD_ASSERT(label, clk, rst, prop)
`define ACD_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== rtl/acd_pkg.sv =====
// ----------------------------------------------------------------------------
// acd_pkg
// Types, constants and helper functions of the collision detector.
// ----------------------------------------------------------------------------
`default_nettype none

package acd_pkg;

  localparam int BYTE_W    = 8;
  localparam int AXIS_W    = 12;
  localparam int THR_W     = 14;
  localparam int CFG_IDX_W = 3;
  localparam int HIT_W     = 2;
  localparam int LEVEL_W   = 2;
  localparam int LEVELS    = 4;

  localparam logic [HIT_W-1:0] HIT_MAX            = 2'd3;
  localparam logic [HIT_W-1:0] HITS_FOR_COLLISION = 2'd2;

  localparam logic [THR_W-1:0] THR_RESET_L0 = 14'd10000;
  localparam logic [THR_W-1:0] THR_RESET_L1 = 14'd1200;
  localparam logic [THR_W-1:0] THR_RESET_L2 = 14'd900;
  localparam logic [THR_W-1:0] THR_RESET_L3 = 14'd600;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENSITIVITY = 3'd0,
    REG_THRESHOLD0  = 3'd1,
    REG_THRESHOLD1  = 3'd2,
    REG_THRESHOLD2  = 3'd3,
    REG_THRESHOLD3  = 3'd4
  } cfg_reg_t;

  // One raw sample beat as it arrives from the sensor.
  typedef struct packed {
    logic [BYTE_W-1:0] x_low;
    logic [BYTE_W-1:0] x_high;
    logic [BYTE_W-1:0] y_low;
    logic [BYTE_W-1:0] y_high;
    logic [BYTE_W-1:0] z_low;
    logic [BYTE_W-1:0] z_high;
  } raw_sample_t;

  // Control from the pipeline to the detector core.
  typedef struct packed {
    logic advance;   // input stage moves into the result register
  } step_ctrl_t;

  // 16-bit word >>> 4: the low nibble of the low byte drops out.
  function automatic logic signed [AXIS_W-1:0] axis_value(
    input logic [BYTE_W-1:0] lo,
    input logic [BYTE_W-1:0] hi
  );
    return $signed({hi, lo[BYTE_W-1:4]});
  endfunction

  function automatic logic [AXIS_W-1:0] abs_delta(
    input logic signed [AXIS_W-1:0] a,
    input logic signed [AXIS_W-1:0] b
  );
    logic signed [AXIS_W:0] d;
    logic signed [AXIS_W:0] nd;
    d  = {a[AXIS_W-1], a} - {b[AXIS_W-1], b};
    nd = -d;
    return d[AXIS_W] ? nd[AXIS_W-1:0] : d[AXIS_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/acd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// acd_cfg_regs
// Sensitivity and threshold registers; presents the active threshold.
// ----------------------------------------------------------------------------
`default_nettype none

`include "accel_collision_detector_macros.svh"

module acd_cfg_regs
  import acd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THR_W-1:0]     cfg_data,
  output logic [THR_W-1:0]     threshold
);

  logic [LEVEL_W-1:0] sensitivity_level;
  logic [THR_W-1:0]   threshold_level [LEVELS];

  always_ff @(posedge clk) begin
    if (rst) begin
      sensitivity_level  <= '0;
      threshold_level[0] <= THR_RESET_L0;
      threshold_level[1] <= THR_RESET_L1;
      threshold_level[2] <= THR_RESET_L2;
      threshold_level[3] <= THR_RESET_L3;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SENSITIVITY: sensitivity_level  <= cfg_data[LEVEL_W-1:0];
        REG_THRESHOLD0:  threshold_level[0] <= cfg_data;
        REG_THRESHOLD1:  threshold_level[1] <= cfg_data;
        REG_THRESHOLD2:  threshold_level[2] <= cfg_data;
        REG_THRESHOLD3:  threshold_level[3] <= cfg_data;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  assign threshold = threshold_level[sensitivity_level];

  `ACD_ASSERT(a_level_write, clk, rst, (cfg_write && cfg_index == REG_SENSITIVITY) |=> (sensitivity_level == $past(cfg_data[LEVEL_W-1:0])))

endmodule

`default_nettype wire

// ===== rtl/acd_detect.sv =====
// ----------------------------------------------------------------------------
// acd_detect
// Per-axis delta compare, hit counter and previous-sample state.
// ----------------------------------------------------------------------------
`default_nettype none

`include "accel_collision_detector_macros.svh"

module acd_detect
  import acd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  step_ctrl_t         ctrl,
  input  raw_sample_t        sample,
  input  logic [THR_W-1:0]   threshold,
  output logic               collision_next
);

  logic signed [AXIS_W-1:0] prev_sample_x;
  logic signed [AXIS_W-1:0] prev_sample_y;
  logic signed [AXIS_W-1:0] prev_sample_z;
  logic                     seeded;
  logic [HIT_W-1:0]         hit_count;
  logic [HIT_W-1:0]         hit_count_next;

  logic signed [AXIS_W-1:0] x;
  logic signed [AXIS_W-1:0] y;
  logic signed [AXIS_W-1:0] z;
  logic                     over_x;
  logic                     over_y;
  logic                     over_z;
  logic [HIT_W-1:0]         hit_inc;

  assign x = axis_value(sample.x_low, sample.x_high);
  assign y = axis_value(sample.y_low, sample.y_high);
  assign z = axis_value(sample.z_low, sample.z_high);

  // First sample only seeds: the compares are gated until seeded, so nothing is over.
  assign over_x = seeded && ({2'b00, abs_delta(x, prev_sample_x)} > threshold);
  assign over_y = seeded && ({2'b00, abs_delta(y, prev_sample_y)} > threshold);
  assign over_z = seeded && ({2'b00, abs_delta(z, prev_sample_z)} > threshold);

  assign hit_inc = (hit_count == HIT_MAX) ? HIT_MAX : hit_count + 2'd1;

  // Z/X wins over Y; Y alone flags at once, counter untouched; a quiet beat clears it.
  always_comb begin
    hit_count_next = '0;
    collision_next = 1'b0;
    if (over_z || over_x) begin
      hit_count_next = hit_inc;
      collision_next = (hit_inc >= HITS_FOR_COLLISION);
    end else if (over_y) begin
      hit_count_next = hit_count;
      collision_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seeded    <= 1'b0;
      hit_count <= '0;
    end else if (ctrl.advance) begin
      seeded    <= 1'b1;
      hit_count <= hit_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sample_x <= '0;
      prev_sample_y <= '0;
      prev_sample_z <= '0;
    end else if (ctrl.advance) begin
      prev_sample_x <= x;
      prev_sample_y <= y;
      prev_sample_z <= z;
    end
  end

  `ACD_ASSERT_ALWAYS(a_unseeded_no_hits, clk, (!seeded) |-> (hit_count == '0))
  `ACD_ASSERT(a_first_beat_quiet, clk, rst, (ctrl.advance && !seeded) |-> !collision_next)

endmodule

`default_nettype wire

// ===== rtl/accel_collision_detector.sv =====
// ----------------------------------------------------------------------------
// accel_collision_detector
// Accelerometer collision detector, one sample beat in, one flag beat out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one beat carries the six raw bytes of
//   an X/Y/Z sample. Output channel (out_valid / out_stall): one beat per
//   input beat carrying collision, in input order.
//   Config port: cfg_write with cfg_index 0 = sensitivity level, 1..4 =
//   thresholds of levels 0..3; other indexes are ignored. Write only while
//   the block is empty.
//   Path: input beat to output beat through the input register, then the
//   result register, with the single compare/count pass between the two.
//   Throughput: one beat per cycle while out_stall is low.
//   Reset: thresholds return to 10000/1200/900/600, level 0, no sample seen,
//   hit counter clear, both stages empty. The first sample after reset only
//   seeds the previous values and reports no collision.
//   Stall: a stalled result holds in the output register; one more beat can
//   still be taken into the input register, after which in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

`include "accel_collision_detector_macros.svh"

module accel_collision_detector
  import acd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // sample channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    x_low_byte,
  input  logic [BYTE_W-1:0]    x_high_byte,
  input  logic [BYTE_W-1:0]    y_low_byte,
  input  logic [BYTE_W-1:0]    y_high_byte,
  input  logic [BYTE_W-1:0]    z_low_byte,
  input  logic [BYTE_W-1:0]    z_high_byte,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 collision,
  // config port
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THR_W-1:0]     cfg_data
);

  // Input stage
  logic        s1_valid;
  raw_sample_t s1_sample;

  logic             in_take;
  step_ctrl_t       ctrl;
  logic [THR_W-1:0] threshold;
  logic             collision_next;

  // Stage 1 moves on whenever the result register is empty or being drained.
  assign ctrl.advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall     = s1_valid && out_valid && out_stall;
  assign in_take      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (ctrl.advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_sample <= '{x_low:  x_low_byte,  x_high: x_high_byte,
                     y_low:  y_low_byte,  y_high: y_high_byte,
                     z_low:  z_low_byte,  z_high: z_high_byte};
    end
  end

  acd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .threshold (threshold)
  );

  // Delta compare and hit counting; state commits on advance.
  acd_detect u_detect (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .sample         (s1_sample),
    .threshold      (threshold),
    .collision_next (collision_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      collision <= collision_next;
    end
  end

  `ACD_ASSERT(a_advance_lands, clk, rst, ctrl.advance |=> (out_valid && (collision == $past(collision_next))))
  `ACD_ASSERT(a_s1_holds, clk, rst, (s1_valid && !ctrl.advance) |=> (s1_valid && (s1_sample == $past(s1_sample))))

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for accel_collision_detector. A sample-level model of
// the detector predicts the collision flag of every sample beat. Checks cover
// first-sample seeding, reset thresholds, the hit counter and extreme thresholds,
// then random phases with ignored register indexes under random back-pressure.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import acd_pkg::*;

  localparam int LATENCY       = 2;       // input register + result register
  localparam int MAX_GAP       = 15;      // longest idle/stall drawn per beat
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 160;
  localparam int AXIS_MAX      = (1 << (AXIS_W - 1)) - 1;   //  2047
  localparam int AXIS_MIN      = -(1 << (AXIS_W - 1));      // -2048
  localparam int SPAN_MAX      = (1 << AXIS_W) - 1;         //  4095
  localparam int THR_MAX       = (1 << THR_W) - 1;          // 16383

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  logic [BYTE_W-1:0]    x_low_byte  = '0;
  logic [BYTE_W-1:0]    x_high_byte = '0;
  logic [BYTE_W-1:0]    y_low_byte  = '0;
  logic [BYTE_W-1:0]    y_high_byte = '0;
  logic [BYTE_W-1:0]    z_low_byte  = '0;
  logic [BYTE_W-1:0]    z_high_byte = '0;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  logic                 collision;
  logic                 cfg_write   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [THR_W-1:0]     cfg_data    = '0;

  accel_collision_detector DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .x_low_byte  (x_low_byte),
    .x_high_byte (x_high_byte),
    .y_low_byte  (y_low_byte),
    .y_high_byte (y_high_byte),
    .z_low_byte  (z_low_byte),
    .z_high_byte (z_high_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .collision   (collision),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Detector model: own copy of the registers and the per-sample state
  // --------------------------------------------------------------------------
  logic [LEVEL_W-1:0]       m_level;
  logic [THR_W-1:0]         m_thr [LEVELS];
  logic signed [AXIS_W-1:0] m_px, m_py, m_pz;
  bit                       m_seeded;
  logic [HIT_W-1:0]         m_hits;

  bit collision_due [$];   // predicted flags, oldest first

  int  errors;
  int  results_seen;
  int  collisions_seen;
  int  samples_sent;
  int  directed_samples;
  int  cfg_writes;
  bit  send_idle = 1'b1;   // sender draws gaps
  bit  recv_idle = 1'b1;   // receiver draws stalls
  int  stall_left;
  int  cycles;

  // stimulus walk: last axis values sent and the threshold in force
  int  gen_x, gen_y, gen_z;
  int  gen_thr;

  // Sensor word is {high, low}; the sample is its top 12 bits, sign kept.
  function automatic logic signed [AXIS_W-1:0] axis_of(input logic [BYTE_W-1:0] lo,
                                                       input logic [BYTE_W-1:0] hi);
    logic signed [15:0] word;
    logic signed [15:0] shifted;
    word    = {hi, lo};
    shifted = word >>> 4;
    return shifted[AXIS_W-1:0];
  endfunction

  function automatic int magnitude(input int v);
    return (v < 0) ? -v : v;
  endfunction

  // Judge one sample and advance the model state.
  function automatic bit judge_sample(input raw_sample_t s);
    logic signed [AXIS_W-1:0] x, y, z;
    int thr;
    bit over_x, over_y, over_z;
    bit hit;
    x   = axis_of(s.x_low, s.x_high);
    y   = axis_of(s.y_low, s.y_high);
    z   = axis_of(s.z_low, s.z_high);
    thr = int'(m_thr[m_level]);
    hit = 1'b0;
    // first sample after reset: change is zero on every axis
    if (!m_seeded) begin
      m_px     = x;
      m_py     = y;
      m_pz     = z;
      m_seeded = 1'b1;
    end
    over_x = magnitude(int'(x) - int'(m_px)) > thr;
    over_y = magnitude(int'(y) - int'(m_py)) > thr;
    over_z = magnitude(int'(z) - int'(m_pz)) > thr;
    if (over_z || over_x) begin
      // Z/X wins over Y; counter saturates at its top
      if (m_hits < HIT_MAX) m_hits = m_hits + 1'b1;
      hit = (m_hits >= HITS_FOR_COLLISION);
    end else if (over_y) begin
      hit = 1'b1;               // Y alone: immediate, counter untouched
    end else begin
      m_hits = '0;
    end
    m_px = x;
    m_py = y;
    m_pz = z;
    return hit;
  endfunction

  // Build a raw beat from axis values; the unused low nibbles are random.
  function automatic raw_sample_t pack_axes(input int x, input int y, input int z);
    raw_sample_t s;
    logic [AXIS_W-1:0] vx, vy, vz;
    vx = x[AXIS_W-1:0];
    vy = y[AXIS_W-1:0];
    vz = z[AXIS_W-1:0];
    s.x_low       = BYTE_W'($urandom_range(0, 255));
    s.y_low       = BYTE_W'($urandom_range(0, 255));
    s.z_low       = BYTE_W'($urandom_range(0, 255));
    s.x_low[7:4]  = vx[3:0];
    s.y_low[7:4]  = vy[3:0];
    s.z_low[7:4]  = vz[3:0];
    s.x_high      = vx[AXIS_W-1:4];
    s.y_high      = vy[AXIS_W-1:4];
    s.z_high      = vz[AXIS_W-1:4];
    return s;
  endfunction

  // One axis step of the random walk: mostly inside the threshold, some just
  // past it, some right on it. jump forces a step past it.
  function automatic int step_axis(input int v, input bit jump);
    int pick;
    int d;
    int nv;
    pick = jump ? 2 : $urandom_range(0, 3);
    case (pick)
      0, 1:    d = int'($urandom_range(0, 2 * gen_thr)) - gen_thr;
      2:       d = gen_thr + 1 + int'($urandom_range(0, 3));
      default: d = gen_thr - int'($urandom_range(0, 1));
    endcase
    if ($urandom_range(0, 1)) d = -d;
    nv = v + d;
    if (nv > AXIS_MAX || nv < AXIS_MIN) nv = v - d;   // bounce off the rail
    if (nv > AXIS_MAX) nv = AXIS_MAX;
    if (nv < AXIS_MIN) nv = AXIS_MIN;
    return nv;
  endfunction

  function automatic raw_sample_t next_sample();
    int kind;
    raw_sample_t s;
    kind = $urandom_range(0, 99);
    if (kind < 50) begin
      gen_x = step_axis(gen_x, 1'b0);
      gen_y = step_axis(gen_y, 1'b0);
      gen_z = step_axis(gen_z, 1'b0);
    end else if (kind < 70) begin
      // a single axis jumps, the others hold
      case ($urandom_range(0, 2))
        0:       gen_x = step_axis(gen_x, 1'b1);
        1:       gen_y = step_axis(gen_y, 1'b1);
        default: gen_z = step_axis(gen_z, 1'b1);
      endcase
    end
    // 70..84: repeat the last sample, a quiet beat
    if (kind < 85) begin
      s = pack_axes(gen_x, gen_y, gen_z);
    end else begin
      // noise: every byte random, walk restarts from it
      s.x_low  = BYTE_W'($urandom_range(0, 255));
      s.x_high = BYTE_W'($urandom_range(0, 255));
      s.y_low  = BYTE_W'($urandom_range(0, 255));
      s.y_high = BYTE_W'($urandom_range(0, 255));
      s.z_low  = BYTE_W'($urandom_range(0, 255));
      s.z_high = BYTE_W'($urandom_range(0, 255));
      gen_x    = int'(axis_of(s.x_low, s.x_high));
      gen_y    = int'(axis_of(s.y_low, s.y_high));
      gen_z    = int'(axis_of(s.z_low, s.z_high));
    end
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Driving tasks; all are entered at a rising edge
  // --------------------------------------------------------------------------

  // Send one sample beat. valid stays high after the beat so that a
  // zero-gap follower goes out back to back.
  task automatic send_sample(input raw_sample_t s);
    int gap;
    gap = send_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    x_low_byte  <= s.x_low;
    x_high_byte <= s.x_high;
    y_low_byte  <= s.y_low;
    y_high_byte <= s.y_high;
    z_low_byte  <= s.z_low;
    z_high_byte <= s.z_high;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    collision_due.push_back(judge_sample(s));
    samples_sent++;
  endtask

  // Drop valid and wait until every predicted flag has come back; already
  // drained means valid is low and there is nothing to wait for.
  task automatic wait_idle();
    if (collision_due.size() != 0) begin
      in_valid <= 1'b0;
      while (collision_due.size() != 0) @(posedge clk);
    end
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_SENSITIVITY: m_level  = data[LEVEL_W-1:0];
      REG_THRESHOLD0:  m_thr[0] = data;
      REG_THRESHOLD1:  m_thr[1] = data;
      REG_THRESHOLD2:  m_thr[2] = data;
      REG_THRESHOLD3:  m_thr[3] = data;
      default: ;                         // unused index, no effect
    endcase
    cfg_write <= 1'b0;
    cfg_writes++;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall per beat, compare against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    bit due;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (collision === 1'b1) collisions_seen++;
        if (collision_due.size() == 0) begin
          $error("collision beat with nothing expected: actual %0b", collision);
          errors++;
        end else begin
          due = collision_due.pop_front();
          if (collision !== due) begin
            $error("collision: expected %0b, actual %0b", due, collision);
            errors++;
          end
        end
        stall_left = recv_idle ? $urandom_range(0, MAX_GAP) : 0;
      end
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d flags still due", cycles, collision_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // The first beat after reset only seeds the history. A Y swing from the
  // reset value of zero would be over 900, yet must not flag.
  task automatic test_first_sample();
    write_cfg(REG_SENSITIVITY, 14'd2);
    send_sample(pack_axes(0, AXIS_MIN, 0));
    send_sample(pack_axes(0, AXIS_MIN, 0));
  endtask

  // Reset thresholds per level: a change equal to the threshold is quiet,
  // one more flags (Y alone, so no counter involved).
  task automatic test_default_thresholds();
    send_sample(pack_axes(0, AXIS_MIN + 900, 0));          // level 2, == 900
    send_sample(pack_axes(0, AXIS_MIN + 900 + 901, 0));    // 901
    wait_idle();
    write_cfg(REG_SENSITIVITY, 14'd1);
    send_sample(pack_axes(0, -247 + 1200, 0));             // == 1200
    send_sample(pack_axes(0, 953 - 1201, 0));              // 1201
    wait_idle();
    write_cfg(REG_SENSITIVITY, 14'd3);
    send_sample(pack_axes(0, -248 + 600, 0));              // == 600
    send_sample(pack_axes(0, 352 + 601, 0));               // 601
    wait_idle();
    // level 0 threshold is beyond any possible swing
    write_cfg(REG_SENSITIVITY, 14'd0);
    send_sample(pack_axes(0, AXIS_MIN, 0));
    send_sample(pack_axes(0, AXIS_MAX, 0));
  endtask

  // Hit counter: two Z/X hits to flag, saturation, Y-only flag that keeps
  // the count, clear on a quiet beat, Z/X taking precedence over Y.
  task automatic test_hit_counter();
    wait_idle();
    write_cfg(REG_THRESHOLD3, 14'd100);
    write_cfg(REG_SENSITIVITY, 14'd3);
    send_sample(pack_axes(0,   AXIS_MAX, 200));   // Z hit, count 1
    send_sample(pack_axes(0,   AXIS_MAX, 0));     // count 2, flag
    send_sample(pack_axes(300, AXIS_MAX, 0));     // count at top
    send_sample(pack_axes(0,   AXIS_MAX, 200));   // stays at top
    send_sample(pack_axes(0,   1800, 200));       // Y alone
    send_sample(pack_axes(0,   1800, 200));       // quiet, clears
    send_sample(pack_axes(150, 1800, 200));       // X hit, count 1
    send_sample(pack_axes(150, 1500, 200));       // Y alone, count kept
    send_sample(pack_axes(0,   1000, 200));       // X+Y, count 2
    send_sample(pack_axes(0,   1000, 200));       // quiet
    send_sample(pack_axes(200, 500, 200));        // X+Y, count 1, no flag
  endtask

  // Threshold extremes: zero (any change counts), all ones, full-swing edge.
  task automatic test_threshold_extremes();
    wait_idle();
    write_cfg(REG_THRESHOLD3, 14'd0);
    send_sample(pack_axes(201, 500, 200));        // one LSB of X
    send_sample(pack_axes(201, 500, 200));
    wait_idle();
    write_cfg(REG_THRESHOLD3, THR_MAX[THR_W-1:0]);
    send_sample(pack_axes(201, 500, AXIS_MAX));
    send_sample(pack_axes(201, 500, AXIS_MIN));   // full swing, still quiet
    wait_idle();
    write_cfg(REG_THRESHOLD3, SPAN_MAX[THR_W-1:0] - 1'b1);
    send_sample(pack_axes(201, 500, AXIS_MAX));   // full swing just over
    send_sample(pack_axes(201, 500, AXIS_MIN));
  endtask

  // Random phases: each one sets all registers (plus a write to an unused
  // index that must change nothing), picks an idling mode and runs a walk
  // around the active threshold. Now and then the sender drains the block.
  task automatic test_random_phases();
    int p, i, mode;
    logic [THR_W-1:0]     thr_pick [LEVELS];
    logic [THR_W-1:0]     data;
    logic [LEVEL_W-1:0]   lvl;
    logic [CFG_IDX_W-1:0] bad_idx;
    gen_x = int'(m_px);
    gen_y = int'(m_py);
    gen_z = int'(m_pz);
    for (p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      lvl = LEVEL_W'(p % LEVELS);
      for (i = 0; i < LEVELS; i++) begin
        if (p == 0) begin
          thr_pick[i] = '0;
        end else if (p == 1) begin
          thr_pick[i] = THR_MAX[THR_W-1:0];
        end else begin
          case ($urandom_range(0, 7))
            0:       thr_pick[i] = '0;
            1:       thr_pick[i] = THR_MAX[THR_W-1:0];
            2:       thr_pick[i] = SPAN_MAX[THR_W-1:0];
            3:       thr_pick[i] = SPAN_MAX[THR_W-1:0] - 1'b1;
            4, 5:    thr_pick[i] = THR_W'($urandom_range(1, 300));
            6:       thr_pick[i] = THR_W'($urandom_range(300, 2000));
            default: thr_pick[i] = THR_W'($urandom_range(0, THR_MAX));
          endcase
        end
      end
      // upper data bits of the level write are don't-care
      data          = THR_W'($urandom_range(0, THR_MAX));
      data[LEVEL_W-1:0] = lvl;
      write_cfg(REG_SENSITIVITY, data);
      write_cfg(REG_THRESHOLD0, thr_pick[0]);
      write_cfg(REG_THRESHOLD1, thr_pick[1]);
      write_cfg(REG_THRESHOLD2, thr_pick[2]);
      write_cfg(REG_THRESHOLD3, thr_pick[3]);
      bad_idx = CFG_IDX_W'($urandom_range(int'(REG_THRESHOLD3) + 1, (1 << CFG_IDX_W) - 1));
      write_cfg(bad_idx, THR_W'($urandom_range(0, THR_MAX)));
      gen_thr = (int'(thr_pick[lvl]) > SPAN_MAX) ? SPAN_MAX : int'(thr_pick[lvl]);
      // 0: both idle, 1: none, 2: receiver only, 3: sender only
      mode      = p % 4;
      send_idle = (mode == 0) || (mode == 3);
      recv_idle = (mode == 0) || (mode == 2);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        send_sample(next_sample());
        if ($urandom_range(0, 63) == 0) wait_idle();
      end
    end
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    // model matches the block's reset state
    m_level  = '0;
    m_thr[0] = THR_RESET_L0;
    m_thr[1] = THR_RESET_L1;
    m_thr[2] = THR_RESET_L2;
    m_thr[3] = THR_RESET_L3;
    m_px     = '0;
    m_py     = '0;
    m_pz     = '0;
    m_seeded = 1'b0;
    m_hits   = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_first_sample();
    test_default_thresholds();
    test_hit_counter();
    test_threshold_extremes();
    directed_samples = samples_sent;
    test_random_phases();

    wait_idle();
    // anything arriving now is an unexpected beat
    repeat (LATENCY + 4) @(posedge clk);

    $display("Run: %0d sample beats (%0d directed), %0d flag beats, %0d collisions",
             samples_sent, directed_samples, results_seen, collisions_seen);
    $display("  %0d reg writes; random phases swept all levels and threshold extremes",
             cfg_writes);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/acd_pkg.sv
rtl/acd_cfg_regs.sv
rtl/acd_detect.sv
rtl/accel_collision_detector.sv
sim/testbench.sv
